[src/point_mass_seek_bounce_step_defines.svh]
// Assertion macros for the point mass stepper.
// Each macro checks a property on the rising edge of clk while arst_n is high.
`ifndef POINT_MASS_SEEK_BOUNCE_STEP_DEFINES_SVH
`define POINT_MASS_SEEK_BOUNCE_STEP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define PMSB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PMSB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PMSB_ASSERT_IMP(lbl, ante, cons, msg)
`define PMSB_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[src/pmsb_pkg.sv]
package pmsb_pkg;

	// Fixed point format of positions and velocities.
	localparam int FRAC_BITS = 8;

	localparam int POS_W   = 20;
	localparam int VEL_W   = 16;
	localparam int COORD_W = 12;
	localparam int GAIN_W  = 11;
	localparam int FRIC_W  = 16;

	// Offset to target, multiplier operands and products.
	localparam int DIFF_W = POS_W + 1;
	localparam int OPND_W = DIFF_W;
	localparam int PROD_W = 2 * OPND_W;

	// Root and divide unit.
	localparam int RAD_W      = PROD_W;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int NUM_W      = POS_W + GAIN_W;
	localparam int QUOT_BITS  = GAIN_W;
	localparam int REM_W      = ROOT_W + 2;
	localparam int SUB_W      = REM_W + 2;
	localparam int STEP_CNT_W = 5;
	localparam logic [STEP_CNT_W-1:0] ROOT_LAST = STEP_CNT_W'(ROOT_W - 1);
	localparam logic [STEP_CNT_W-1:0] DIV_LAST  = STEP_CNT_W'(QUOT_BITS - 1);

	// Update arithmetic.
	localparam int ACC_W      = GAIN_W + 1;
	localparam int VSUM_W     = VEL_W + 1;
	localparam int PSUM_W     = POS_W + 2;
	localparam int VEL_LIM    = 64 << FRAC_BITS;
	localparam int FRIC_SHIFT = 16;

	// Reset values.
	localparam logic [POS_W-1:0]   POS_X_RST = POS_W'(600 << FRAC_BITS);
	localparam logic [POS_W-1:0]   POS_Y_RST = POS_W'(400 << FRAC_BITS);
	localparam logic [VEL_W-1:0]   VEL_RST   = VEL_W'(2 << FRAC_BITS);
	localparam logic [COORD_W-1:0] ARENA_W_RST = COORD_W'(1200);
	localparam logic [COORD_W-1:0] ARENA_H_RST = COORD_W'(800);
	localparam logic [GAIN_W-1:0]  GAIN_RST    = GAIN_W'(128);
	localparam logic [FRIC_W-1:0]  FRIC_RST    = FRIC_W'(62259);

	// Register port.
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		REG_ARENA_W,
		REG_ARENA_H,
		REG_SEEK_GAIN,
		REG_FRICTION
	} pmsb_reg_t;

	typedef enum logic {
		RD_ROOT,
		RD_DIV
	} pmsb_rd_op_t;

	typedef struct packed {
		logic              start;
		pmsb_rd_op_t       op;
		logic [RAD_W-1:0]  rad;
		logic [NUM_W-1:0]  num;
		logic [ROOT_W-1:0] divisor;
	} pmsb_rd_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] result;
	} pmsb_rd_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_X,
		ST_SQ_Y,
		ST_ROOT_GO,
		ST_ROOT,
		ST_GAIN_X,
		ST_GAIN_Y,
		ST_DIV_X_GO,
		ST_DIV_X,
		ST_DIV_Y_GO,
		ST_DIV_Y,
		ST_UPDATE,
		ST_DAMP_X,
		ST_DAMP_Y,
		ST_DAMP_FIN,
		ST_OUT
	} pmsb_state_t;

endpackage

[src/pmsb_mul.sv]
// Shared signed multiplier with a registered product.
module pmsb_mul (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [pmsb_pkg::OPND_W-1:0]     a,
	input  logic signed [pmsb_pkg::OPND_W-1:0]     b,
	output logic signed [pmsb_pkg::PROD_W-1:0]     p
);

	logic signed [pmsb_pkg::PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

	assign p = p_q;

endmodule

[src/pmsb_rootdiv.sv]
// Shared iterative unit: floor square root (two radicand bits per step) or
// restoring division (one quotient bit per step). Both use one subtractor.
module pmsb_rootdiv (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pmsb_pkg::pmsb_rd_req_t req,
	output pmsb_pkg::pmsb_rd_rsp_t rsp
);

	logic                                 busy_q;
	logic                                 done_q;
	logic [pmsb_pkg::STEP_CNT_W-1:0]      cnt_q;
	pmsb_pkg::pmsb_rd_op_t                op_q;
	logic [pmsb_pkg::REM_W-1:0]           rem_q;
	logic [pmsb_pkg::ROOT_W-1:0]          res_q;
	logic [pmsb_pkg::RAD_W-1:0]           sh_q;
	logic [pmsb_pkg::ROOT_W-1:0]          div_q;

	logic [pmsb_pkg::SUB_W-1:0]           sub_a;
	logic [pmsb_pkg::SUB_W-1:0]           sub_b;
	logic [pmsb_pkg::SUB_W:0]             diff;
	logic                                 take;

	// Operand selection for the shared subtractor.
	always_comb begin
		if (op_q == pmsb_pkg::RD_ROOT) begin
			sub_a = {rem_q, sh_q[pmsb_pkg::RAD_W-1 -: 2]};
			sub_b = {2'b00, res_q, 2'b01};
		end else begin
			sub_a = {2'b00, rem_q[pmsb_pkg::REM_W-2:0], sh_q[pmsb_pkg::RAD_W-1]};
			sub_b = {4'b0000, div_q};
		end
		diff = {1'b0, sub_a} - {1'b0, sub_b};
		take = !diff[pmsb_pkg::SUB_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == pmsb_pkg::RD_ROOT) ? pmsb_pkg::ROOT_LAST
				                                        : pmsb_pkg::DIV_LAST;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			res_q <= '0;
			div_q <= req.divisor;
			if (req.op == pmsb_pkg::RD_ROOT) begin
				rem_q <= '0;
				sh_q  <= req.rad;
			end else begin
				// The quotient never exceeds the gain, so the high numerator
				// bits already sit below the divisor.
				rem_q <= pmsb_pkg::REM_W'(req.num >> pmsb_pkg::QUOT_BITS);
				sh_q  <= pmsb_pkg::RAD_W'(req.num[pmsb_pkg::QUOT_BITS-1:0])
				         << (pmsb_pkg::RAD_W - pmsb_pkg::QUOT_BITS);
			end
		end else if (busy_q) begin
			rem_q <= take ? diff[pmsb_pkg::REM_W-1:0] : sub_a[pmsb_pkg::REM_W-1:0];
			res_q <= {res_q[pmsb_pkg::ROOT_W-2:0], take};
			sh_q  <= (op_q == pmsb_pkg::RD_ROOT) ? (sh_q << 2) : (sh_q << 1);
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

[src/point_mass_seek_bounce_step.sv]
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   seek_active, target_x, target_y
// out       output     out_valid/out_stall position_x, position_y, velocity_x, velocity_y
// cfg       input      APB psel/penable    arena_width, arena_height, seek_gain, friction
//
// With seek active, the 21-step square root and then the two 11-step divides
// run through the shared root/divide unit. A target on the point skips the
// divides, and a transfer without seek skips the root as well. arst_n clears
// the sequencer, point state, output valid and configuration registers.
// in_stall is high from acceptance until the result is moved to the output
// register; a held result waits there while the next transfer is taken.
`include "point_mass_seek_bounce_step_defines.svh"

module point_mass_seek_bounce_step (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  seek_active,
	input  logic [pmsb_pkg::COORD_W-1:0]          target_x,
	input  logic [pmsb_pkg::COORD_W-1:0]          target_y,

	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [pmsb_pkg::POS_W-1:0]            position_x,
	output logic [pmsb_pkg::POS_W-1:0]            position_y,
	output logic signed [pmsb_pkg::VEL_W-1:0]     velocity_x,
	output logic signed [pmsb_pkg::VEL_W-1:0]     velocity_y,

	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [pmsb_pkg::ADDR_W-1:0]           paddr,
	input  logic [pmsb_pkg::DATA_W-1:0]           pwdata,
	output logic [pmsb_pkg::DATA_W-1:0]           prdata,
	output logic                                  pready
);

	// Position and velocity after the wall check, before damping.
	typedef struct packed {
		logic [pmsb_pkg::POS_W-1:0]         pos;
		logic signed [pmsb_pkg::VSUM_W-1:0] vel;
	} axis_t;

	localparam logic signed [pmsb_pkg::PROD_W-1:0] LIM_P = pmsb_pkg::PROD_W'(pmsb_pkg::VEL_LIM);

	// Configuration registers.
	logic [pmsb_pkg::COORD_W-1:0] arena_w_q;
	logic [pmsb_pkg::COORD_W-1:0] arena_h_q;
	logic [pmsb_pkg::GAIN_W-1:0]  seek_gain_q;
	logic [pmsb_pkg::FRIC_W-1:0]  friction_q;

	// Point state.
	logic [pmsb_pkg::POS_W-1:0]         pos_x_q;
	logic [pmsb_pkg::POS_W-1:0]         pos_y_q;
	logic signed [pmsb_pkg::VEL_W-1:0]  vel_x_q;
	logic signed [pmsb_pkg::VEL_W-1:0]  vel_y_q;

	// Working registers of one tick.
	pmsb_pkg::pmsb_state_t               state_q;
	pmsb_pkg::pmsb_state_t               state_d;
	logic signed [pmsb_pkg::DIFF_W-1:0]  dx_q;
	logic signed [pmsb_pkg::DIFF_W-1:0]  dy_q;
	logic signed [pmsb_pkg::PROD_W-1:0]  acc_q;
	logic [pmsb_pkg::ROOT_W-1:0]         len_q;
	logic signed [pmsb_pkg::ACC_W-1:0]   ax_q;
	logic signed [pmsb_pkg::ACC_W-1:0]   ay_q;
	logic signed [pmsb_pkg::VSUM_W-1:0]  vtmp_x_q;
	logic signed [pmsb_pkg::VSUM_W-1:0]  vtmp_y_q;

	// Output register.
	logic                                out_valid_q;
	logic [pmsb_pkg::POS_W-1:0]          out_pos_x_q;
	logic [pmsb_pkg::POS_W-1:0]          out_pos_y_q;
	logic signed [pmsb_pkg::VEL_W-1:0]   out_vel_x_q;
	logic signed [pmsb_pkg::VEL_W-1:0]   out_vel_y_q;

	// Shared units and their controls.
	logic                                mul_en;
	logic signed [pmsb_pkg::OPND_W-1:0]  mul_a;
	logic signed [pmsb_pkg::OPND_W-1:0]  mul_b;
	logic signed [pmsb_pkg::PROD_W-1:0]  mul_p;
	pmsb_pkg::pmsb_rd_req_t              rd_req;
	pmsb_pkg::pmsb_rd_rsp_t              rd_rsp;

	logic                                in_take;
	logic                                out_load;
	logic                                reg_we;
	logic [pmsb_pkg::POS_W-1:0]          tx_q8;
	logic [pmsb_pkg::POS_W-1:0]          ty_q8;
	logic [pmsb_pkg::POS_W-1:0]          edge_x;
	logic [pmsb_pkg::POS_W-1:0]          edge_y;
	logic signed [pmsb_pkg::PROD_W-1:0]  acc_abs;
	logic signed [pmsb_pkg::PROD_W-1:0]  mul_abs;
	logic signed [pmsb_pkg::ACC_W-1:0]   quot;
	logic signed [pmsb_pkg::PROD_W-1:0]  damp_sh;
	logic signed [pmsb_pkg::VEL_W-1:0]   damp_v;
	axis_t                               upd_x;
	axis_t                               upd_y;

	// One axis of the Euler step: add the acceleration, move, and bounce off
	// either wall by clamping the position and reversing the velocity.
	function automatic axis_t step_axis(
		logic [pmsb_pkg::POS_W-1:0]        p,
		logic signed [pmsb_pkg::VEL_W-1:0] v,
		logic signed [pmsb_pkg::ACC_W-1:0] a,
		logic [pmsb_pkg::POS_W-1:0]        wall
	);
		logic signed [pmsb_pkg::VSUM_W-1:0] vs;
		logic signed [pmsb_pkg::PSUM_W-1:0] ps;
		axis_t                              r;
		vs = {v[pmsb_pkg::VEL_W-1], v}
		   + {{(pmsb_pkg::VSUM_W - pmsb_pkg::ACC_W){a[pmsb_pkg::ACC_W-1]}}, a};
		ps = {2'b00, p} + {{(pmsb_pkg::PSUM_W - pmsb_pkg::VSUM_W){vs[pmsb_pkg::VSUM_W-1]}}, vs};
		if (ps > $signed({2'b00, wall})) begin
			r.pos = wall;
			r.vel = -vs;
		end else if (ps[pmsb_pkg::PSUM_W-1]) begin
			r.pos = '0;
			r.vel = -vs;
		end else begin
			r.pos = ps[pmsb_pkg::POS_W-1:0];
			r.vel = vs;
		end
		return r;
	endfunction

	pmsb_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	pmsb_rootdiv u_rootdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rd_req),
		.rsp    (rd_rsp)
	);

	// The input side is open only while the sequencer waits for a tick.
	assign in_stall = (state_q != pmsb_pkg::ST_IDLE);
	assign in_take  = in_valid && (state_q == pmsb_pkg::ST_IDLE);

	// The finished tick moves to the output register once it is free or drains.
	assign out_load = (state_q == pmsb_pkg::ST_OUT) && (!out_valid_q || !out_stall);

	assign tx_q8  = pmsb_pkg::POS_W'(target_x) << pmsb_pkg::FRAC_BITS;
	assign ty_q8  = pmsb_pkg::POS_W'(target_y) << pmsb_pkg::FRAC_BITS;
	assign edge_x = pmsb_pkg::POS_W'(arena_w_q) << pmsb_pkg::FRAC_BITS;
	assign edge_y = pmsb_pkg::POS_W'(arena_h_q) << pmsb_pkg::FRAC_BITS;

	always_comb begin
		acc_abs = acc_q[pmsb_pkg::PROD_W-1] ? -acc_q : acc_q;
		mul_abs = mul_p[pmsb_pkg::PROD_W-1] ? -mul_p : mul_p;
		quot    = pmsb_pkg::ACC_W'(rd_rsp.result);
		upd_x   = step_axis(pos_x_q, vel_x_q, ax_q, edge_x);
		upd_y   = step_axis(pos_y_q, vel_y_q, ay_q, edge_y);
	end

	// Friction: the product is floored by the arithmetic shift, then the
	// velocity is held within the speed limit.
	always_comb begin
		damp_sh = mul_p >>> pmsb_pkg::FRIC_SHIFT;
		if (damp_sh > LIM_P) begin
			damp_v = pmsb_pkg::VEL_W'(pmsb_pkg::VEL_LIM);
		end else if (damp_sh < -LIM_P) begin
			damp_v = -pmsb_pkg::VEL_W'(pmsb_pkg::VEL_LIM);
		end else begin
			damp_v = damp_sh[pmsb_pkg::VEL_W-1:0];
		end
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pmsb_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = seek_active ? pmsb_pkg::ST_SQ_X : pmsb_pkg::ST_UPDATE;
				end
			end
			pmsb_pkg::ST_SQ_X:     state_d = pmsb_pkg::ST_SQ_Y;
			pmsb_pkg::ST_SQ_Y:     state_d = pmsb_pkg::ST_ROOT_GO;
			pmsb_pkg::ST_ROOT_GO:  state_d = pmsb_pkg::ST_ROOT;
			pmsb_pkg::ST_ROOT: begin
				// A target on the point gives no acceleration.
				if (rd_rsp.done) begin
					state_d = (rd_rsp.result == '0) ? pmsb_pkg::ST_UPDATE
					                                : pmsb_pkg::ST_GAIN_X;
				end
			end
			pmsb_pkg::ST_GAIN_X:   state_d = pmsb_pkg::ST_GAIN_Y;
			pmsb_pkg::ST_GAIN_Y:   state_d = pmsb_pkg::ST_DIV_X_GO;
			pmsb_pkg::ST_DIV_X_GO: state_d = pmsb_pkg::ST_DIV_X;
			pmsb_pkg::ST_DIV_X: begin
				if (rd_rsp.done) begin
					state_d = pmsb_pkg::ST_DIV_Y_GO;
				end
			end
			pmsb_pkg::ST_DIV_Y_GO: state_d = pmsb_pkg::ST_DIV_Y;
			pmsb_pkg::ST_DIV_Y: begin
				if (rd_rsp.done) begin
					state_d = pmsb_pkg::ST_UPDATE;
				end
			end
			pmsb_pkg::ST_UPDATE:   state_d = pmsb_pkg::ST_DAMP_X;
			pmsb_pkg::ST_DAMP_X:   state_d = pmsb_pkg::ST_DAMP_Y;
			pmsb_pkg::ST_DAMP_Y:   state_d = pmsb_pkg::ST_DAMP_FIN;
			pmsb_pkg::ST_DAMP_FIN: state_d = pmsb_pkg::ST_OUT;
			pmsb_pkg::ST_OUT: begin
				if (out_load) begin
					state_d = pmsb_pkg::ST_IDLE;
				end
			end
			default:               state_d = pmsb_pkg::ST_IDLE;
		endcase
	end

	// Controls of the shared multiplier and the root/divide unit.
	always_comb begin
		mul_en         = 1'b0;
		mul_a          = dx_q;
		mul_b          = dx_q;
		rd_req.start   = 1'b0;
		rd_req.op      = pmsb_pkg::RD_ROOT;
		rd_req.rad     = $unsigned(acc_q) + $unsigned(mul_p);
		rd_req.num     = pmsb_pkg::NUM_W'(acc_abs);
		rd_req.divisor = len_q;
		case (state_q)
			pmsb_pkg::ST_SQ_X: begin
				mul_en = 1'b1;
			end
			pmsb_pkg::ST_SQ_Y: begin
				mul_en = 1'b1;
				mul_a  = dy_q;
				mul_b  = dy_q;
			end
			pmsb_pkg::ST_ROOT_GO: begin
				rd_req.start = 1'b1;
			end
			pmsb_pkg::ST_GAIN_X: begin
				mul_en = 1'b1;
				mul_b  = {{(pmsb_pkg::OPND_W - pmsb_pkg::GAIN_W){1'b0}}, seek_gain_q};
			end
			pmsb_pkg::ST_GAIN_Y: begin
				mul_en = 1'b1;
				mul_a  = dy_q;
				mul_b  = {{(pmsb_pkg::OPND_W - pmsb_pkg::GAIN_W){1'b0}}, seek_gain_q};
			end
			pmsb_pkg::ST_DIV_X_GO: begin
				rd_req.start = 1'b1;
				rd_req.op    = pmsb_pkg::RD_DIV;
			end
			pmsb_pkg::ST_DIV_Y_GO: begin
				rd_req.start = 1'b1;
				rd_req.op    = pmsb_pkg::RD_DIV;
				rd_req.num   = pmsb_pkg::NUM_W'(mul_abs);
			end
			pmsb_pkg::ST_DAMP_X: begin
				mul_en = 1'b1;
				mul_a  = {{(pmsb_pkg::OPND_W - pmsb_pkg::VSUM_W){vtmp_x_q[pmsb_pkg::VSUM_W-1]}},
				          vtmp_x_q};
				mul_b  = {{(pmsb_pkg::OPND_W - pmsb_pkg::FRIC_W){1'b0}}, friction_q};
			end
			pmsb_pkg::ST_DAMP_Y: begin
				mul_en = 1'b1;
				mul_a  = {{(pmsb_pkg::OPND_W - pmsb_pkg::VSUM_W){vtmp_y_q[pmsb_pkg::VSUM_W-1]}},
				          vtmp_y_q};
				mul_b  = {{(pmsb_pkg::OPND_W - pmsb_pkg::FRIC_W){1'b0}}, friction_q};
			end
			default: begin
			end
		endcase
	end

	// Sequencer, point state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pmsb_pkg::ST_IDLE;
			pos_x_q     <= pmsb_pkg::POS_X_RST;
			pos_y_q     <= pmsb_pkg::POS_Y_RST;
			vel_x_q     <= pmsb_pkg::VEL_RST;
			vel_y_q     <= pmsb_pkg::VEL_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pmsb_pkg::ST_UPDATE) begin
				pos_x_q <= upd_x.pos;
				pos_y_q <= upd_y.pos;
			end
			if (state_q == pmsb_pkg::ST_DAMP_Y) begin
				vel_x_q <= damp_v;
			end
			if (state_q == pmsb_pkg::ST_DAMP_FIN) begin
				vel_y_q <= damp_v;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working values of the tick and the output payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			dx_q <= pmsb_pkg::DIFF_W'({1'b0, tx_q8}) - pmsb_pkg::DIFF_W'({1'b0, pos_x_q});
			dy_q <= pmsb_pkg::DIFF_W'({1'b0, ty_q8}) - pmsb_pkg::DIFF_W'({1'b0, pos_y_q});
			ax_q <= '0;
			ay_q <= '0;
		end
		if ((state_q == pmsb_pkg::ST_SQ_Y) || (state_q == pmsb_pkg::ST_GAIN_Y)) begin
			acc_q <= mul_p;
		end
		if ((state_q == pmsb_pkg::ST_ROOT) && rd_rsp.done) begin
			len_q <= rd_rsp.result;
		end
		// The quotient is taken toward zero, so the offset sign goes on last.
		if ((state_q == pmsb_pkg::ST_DIV_X) && rd_rsp.done) begin
			ax_q <= dx_q[pmsb_pkg::DIFF_W-1] ? -quot : quot;
		end
		if ((state_q == pmsb_pkg::ST_DIV_Y) && rd_rsp.done) begin
			ay_q <= dy_q[pmsb_pkg::DIFF_W-1] ? -quot : quot;
		end
		if (state_q == pmsb_pkg::ST_UPDATE) begin
			vtmp_x_q <= upd_x.vel;
			vtmp_y_q <= upd_y.vel;
		end
		if (out_load) begin
			out_pos_x_q <= pos_x_q;
			out_pos_y_q <= pos_y_q;
			out_vel_x_q <= vel_x_q;
			out_vel_y_q <= vel_y_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign position_x = out_pos_x_q;
	assign position_y = out_pos_y_q;
	assign velocity_x = out_vel_x_q;
	assign velocity_y = out_vel_y_q;

	// Register port. Writes land in the access cycle; reads return the value.
	assign pready = 1'b1;
	assign reg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_w_q   <= pmsb_pkg::ARENA_W_RST;
			arena_h_q   <= pmsb_pkg::ARENA_H_RST;
			seek_gain_q <= pmsb_pkg::GAIN_RST;
			friction_q  <= pmsb_pkg::FRIC_RST;
		end else if (reg_we) begin
			case (pmsb_pkg::pmsb_reg_t'(paddr[3:2]))
				pmsb_pkg::REG_ARENA_W:   arena_w_q   <= pwdata[pmsb_pkg::COORD_W-1:0];
				pmsb_pkg::REG_ARENA_H:   arena_h_q   <= pwdata[pmsb_pkg::COORD_W-1:0];
				pmsb_pkg::REG_SEEK_GAIN: seek_gain_q <= pwdata[pmsb_pkg::GAIN_W-1:0];
				pmsb_pkg::REG_FRICTION:  friction_q  <= pwdata[pmsb_pkg::FRIC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (pmsb_pkg::pmsb_reg_t'(paddr[3:2]))
			pmsb_pkg::REG_ARENA_W:   prdata = pmsb_pkg::DATA_W'(arena_w_q);
			pmsb_pkg::REG_ARENA_H:   prdata = pmsb_pkg::DATA_W'(arena_h_q);
			pmsb_pkg::REG_SEEK_GAIN: prdata = pmsb_pkg::DATA_W'(seek_gain_q);
			pmsb_pkg::REG_FRICTION:  prdata = pmsb_pkg::DATA_W'(friction_q);
			default:                 prdata = '0;
		endcase
	end

	// The root/divide unit answers only while the sequencer waits for it.
	`PMSB_ASSERT_IMP(a_rd_done_in_wait, rd_rsp.done, (state_q == pmsb_pkg::ST_ROOT) || (state_q == pmsb_pkg::ST_DIV_X) || (state_q == pmsb_pkg::ST_DIV_Y), "root/divide result outside a wait state")

	// The seek acceleration never exceeds the gain.
	`PMSB_ASSERT_IMP(a_quot_le_gain, rd_rsp.done && ((state_q == pmsb_pkg::ST_DIV_X) || (state_q == pmsb_pkg::ST_DIV_Y)), rd_rsp.result <= pmsb_pkg::ROOT_W'(seek_gain_q), "seek quotient above gain")

	// Stored velocity stays within the speed limit.
	`PMSB_ASSERT_IMP(a_vel_sat, 1'b1, (vel_x_q <= $signed(pmsb_pkg::VEL_W'(pmsb_pkg::VEL_LIM))) && (vel_x_q >= -$signed(pmsb_pkg::VEL_W'(pmsb_pkg::VEL_LIM))) && (vel_y_q <= $signed(pmsb_pkg::VEL_W'(pmsb_pkg::VEL_LIM))) && (vel_y_q >= -$signed(pmsb_pkg::VEL_W'(pmsb_pkg::VEL_LIM))), "velocity beyond limit")

	// A result taken with nothing new behind it leaves the output empty.
	`PMSB_ASSERT_NXT(a_out_drains, out_valid && !out_stall && (state_q != pmsb_pkg::ST_OUT), !out_valid, "output held after transfer")

endmodule

[tb/sv/point_mass_seek_bounce_step_tb.sv]
module point_mass_seek_bounce_step_tb;

	// The slowest transfer is one with seek active; allow a margin on top of its
	// time to the result before any register write or the end of the run.
	localparam int SETTLE_CYCLES = 80;

	// One result of the block, and the shape that the tracked point state takes.
	typedef struct {
		logic [pmsb_pkg::POS_W-1:0] pos_x;
		logic [pmsb_pkg::POS_W-1:0] pos_y;
		logic [pmsb_pkg::VEL_W-1:0] vel_x;
		logic [pmsb_pkg::VEL_W-1:0] vel_y;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          seek_active = 1'b0;
	logic [pmsb_pkg::COORD_W-1:0]  target_x = '0;
	logic [pmsb_pkg::COORD_W-1:0]  target_y = '0;

	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic [pmsb_pkg::POS_W-1:0]        position_x;
	logic [pmsb_pkg::POS_W-1:0]        position_y;
	logic signed [pmsb_pkg::VEL_W-1:0] velocity_x;
	logic signed [pmsb_pkg::VEL_W-1:0] velocity_y;

	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [pmsb_pkg::ADDR_W-1:0]   paddr = '0;
	logic [pmsb_pkg::DATA_W-1:0]   pwdata = '0;
	logic [pmsb_pkg::DATA_W-1:0]   prdata;
	logic                          pready;

	// Tracked copy of the block's registers, kept at the widths of the hardware.
	logic [pmsb_pkg::COORD_W-1:0]  arena_w_cfg;
	logic [pmsb_pkg::COORD_W-1:0]  arena_h_cfg;
	logic [pmsb_pkg::GAIN_W-1:0]   gain_cfg;
	logic [pmsb_pkg::FRIC_W-1:0]   fric_cfg;

	// Tracked point state. Positions and velocities stay in range after every
	// tick, but the intermediate sums need the headroom of a 64-bit integer.
	longint              trk_px;
	longint              trk_py;
	longint              trk_vx;
	longint              trk_vy;

	// Points that the block still owes us, oldest first.
	point_t              pending_points[$];

	int                  errors = 0;
	// Percentage of cycles in which the sender idles and the receiver stalls.
	int                  idle_pct = 11;
	// Cycles that the receiver still has to hold off; loaded by a test, counted
	// down by the receiver process itself.
	int                  hold_left = 0;

	point_mass_seek_bounce_step u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.seek_active (seek_active),
		.target_x    (target_x),
		.target_y    (target_y),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.position_x  (position_x),
		.position_y  (position_y),
		.velocity_x  (velocity_x),
		.velocity_y  (velocity_y),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Floor of the square root, found one result bit at a time from the top.
	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	// Friction is a Q0.16 fraction. The product is shifted arithmetically, so
	// negative velocities round toward minus infinity, and then it is limited.
	function automatic longint apply_friction(input longint v);
		longint p;
		p = (v * longint'(fric_cfg)) >>> 16;
		if (p > pmsb_pkg::VEL_LIM)
			p = pmsb_pkg::VEL_LIM;
		if (p < -pmsb_pkg::VEL_LIM)
			p = -pmsb_pkg::VEL_LIM;
		return p;
	endfunction

	// A wall hit clamps the position onto the wall and reverses that axis.
	// Both tests run, so a zero-sized arena still leaves the point at zero.
	task automatic bounce_axis(inout longint p, inout longint v, input longint wall);
		if (p > wall) begin
			p = wall;
			v = -v;
		end
		if (p < 0) begin
			p = 0;
			v = -v;
		end
	endtask

	// One tick of the point: steer, integrate, bounce, damp.
	task automatic advance_point(input logic seek, input logic [pmsb_pkg::COORD_W-1:0] tx,
		input logic [pmsb_pkg::COORD_W-1:0] ty, output point_t res);
		longint ax;
		longint ay;
		longint dx;
		longint dy;
		longint span_len;
		longint wall_x;
		longint wall_y;
		ax = 0;
		ay = 0;
		wall_x = longint'(arena_w_cfg) << pmsb_pkg::FRAC_BITS;
		wall_y = longint'(arena_h_cfg) << pmsb_pkg::FRAC_BITS;
		if (seek) begin
			dx = (longint'(tx) << pmsb_pkg::FRAC_BITS) - trk_px;
			dy = (longint'(ty) << pmsb_pkg::FRAC_BITS) - trk_py;
			span_len = longint'(floor_root(longint'(dx * dx + dy * dy)));
			// With the target right on the point there is no direction to steer in.
			if (span_len != 0) begin
				ax = dx * longint'(gain_cfg) / span_len;
				ay = dy * longint'(gain_cfg) / span_len;
			end
		end
		trk_vx += ax;
		trk_vy += ay;
		trk_px += trk_vx;
		trk_py += trk_vy;
		bounce_axis(trk_px, trk_vx, wall_x);
		bounce_axis(trk_py, trk_vy, wall_y);
		trk_vx = apply_friction(trk_vx);
		trk_vy = apply_friction(trk_vy);
		res.pos_x = pmsb_pkg::POS_W'(trk_px);
		res.pos_y = pmsb_pkg::POS_W'(trk_py);
		res.vel_x = pmsb_pkg::VEL_W'(trk_vx);
		res.vel_y = pmsb_pkg::VEL_W'(trk_vy);
	endtask

	// One register write on the APB port: a setup cycle, then an access cycle
	// that completes at the edge where pready is seen high.
	task automatic reg_write(input pmsb_pkg::pmsb_reg_t idx,
		input logic [pmsb_pkg::DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= pmsb_pkg::ADDR_W'(4 * int'(idx));
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			pmsb_pkg::REG_ARENA_W: begin
				arena_w_cfg = data[pmsb_pkg::COORD_W-1:0];
			end
			pmsb_pkg::REG_ARENA_H: begin
				arena_h_cfg = data[pmsb_pkg::COORD_W-1:0];
			end
			pmsb_pkg::REG_SEEK_GAIN: begin
				gain_cfg = data[pmsb_pkg::GAIN_W-1:0];
			end
			pmsb_pkg::REG_FRICTION: begin
				fric_cfg = data[pmsb_pkg::FRIC_W-1:0];
			end
			default: begin
			end
		endcase
		// One more edge so that a following write does not reassign psel in this step.
		@(posedge clk);
	endtask

	function automatic logic [pmsb_pkg::DATA_W-1:0] with_noise(input int val, input int w);
		logic [pmsb_pkg::DATA_W-1:0] d;
		d = pmsb_pkg::DATA_W'(val);
		if ($urandom_range(3) == 0)
			d = d | (pmsb_pkg::DATA_W'($urandom()) << w);
		return d;
	endfunction

	// Sets all four registers; bits above each field carry noise now and then,
	// since the block must ignore them.
	task automatic set_all_regs(input int aw, input int ah, input int gain, input int fric);
		reg_write(pmsb_pkg::REG_ARENA_W, with_noise(aw, pmsb_pkg::COORD_W));
		reg_write(pmsb_pkg::REG_ARENA_H, with_noise(ah, pmsb_pkg::COORD_W));
		reg_write(pmsb_pkg::REG_SEEK_GAIN, with_noise(gain, pmsb_pkg::GAIN_W));
		reg_write(pmsb_pkg::REG_FRICTION, with_noise(fric, pmsb_pkg::FRIC_W));
	endtask

	// Offers one tick on the input channel, possibly after a few idle cycles,
	// and records the expected point once the transfer has happened.
	task automatic send_tick(input logic seek, input logic [pmsb_pkg::COORD_W-1:0] tx,
		input logic [pmsb_pkg::COORD_W-1:0] ty);
		point_t want;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		seek_active <= seek;
		target_x <= tx;
		target_y <= ty;
		do
			@(posedge clk);
		while (in_stall);
		advance_point(seek, tx, ty, want);
		pending_points.push_back(want);
	endtask

	// Picks a target coordinate: often near the point itself, so that short and
	// zero offsets come up, otherwise inside the arena, at an extreme or anywhere.
	function automatic logic [pmsb_pkg::COORD_W-1:0] pick_coord(input longint pos,
		input int edge_px);
		int c;
		case ($urandom_range(9))
			0: c = $urandom_range(1) ? 4095 : 0;
			1, 2: c = int'(pos >>> pmsb_pkg::FRAC_BITS) + $urandom_range(6) - 3;
			3, 4: c = $urandom_range(edge_px);
			default: c = $urandom_range(4095);
		endcase
		if (c < 0)
			c = 0;
		if (c > 4095)
			c = 4095;
		return pmsb_pkg::COORD_W'(c);
	endfunction

	// Most ticks steer; the rest coast so that the walls and friction show.
	task automatic send_random_tick();
		logic seek;
		logic [pmsb_pkg::COORD_W-1:0] tx;
		logic [pmsb_pkg::COORD_W-1:0] ty;
		seek = ($urandom_range(99) < 75);
		tx = pick_coord(trk_px, int'(arena_w_cfg));
		ty = pick_coord(trk_py, int'(arena_h_cfg));
		send_tick(seek, tx, ty);
	endtask

	// Lowers valid and waits for every owed result, then lets the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Compares one output transfer with the oldest owed point, field by field.
	task automatic check_point();
		point_t want;
		if (pending_points.size() == 0) begin
			$error("result with none owed: position_x %0d position_y %0d",
				position_x, position_y);
			errors++;
		end else begin
			want = pending_points.pop_front();
			if (position_x !== want.pos_x) begin
				$error("position_x: expected %0d, actual %0d", want.pos_x, position_x);
				errors++;
			end
			if (position_y !== want.pos_y) begin
				$error("position_y: expected %0d, actual %0d", want.pos_y, position_y);
				errors++;
			end
			if (velocity_x !== want.vel_x) begin
				$error("velocity_x: expected %0d, actual %0d",
					$signed(want.vel_x), velocity_x);
				errors++;
			end
			if (velocity_y !== want.vel_y) begin
				$error("velocity_y: expected %0d, actual %0d",
					$signed(want.vel_y), velocity_y);
				errors++;
			end
		end
	endtask

	// Receiver. Values are sampled as they stood before the edge, and the stall
	// for the next cycle is driven in the same step. A long hold-off, when a
	// test asks for one, takes priority over the random stalls.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_point();
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < idle_pct);
			end
		end
	end

	// Right after reset the point starts at (600, 400) px moving 2 px per tick on
	// both axes with the reset registers. Steer toward both far corners once.
	task automatic test_reset_state();
		send_tick(1'b0, '0, '0);
		send_tick(1'b1, '0, '0);
		send_tick(1'b1, 12'hFFF, 12'hFFF);
		drain();
	endtask

	// Shrink the arena to one pixel: the point lies outside and must be clamped
	// onto the walls with a bounce. Friction zero stops it dead after each tick,
	// so it sits exactly on a whole pixel and a target right on it can be asked.
	// The gain is written above its nominal range and must be applied as is.
	task automatic test_shrunken_arena();
		set_all_regs(1, 1, 2047, 0);
		send_tick(1'b0, '0, '0);
		send_tick(1'b1, 12'd1, 12'd1);
		send_tick(1'b1, 12'd2, 12'd1);
		send_tick(1'b1, '0, '0);
		drain();
	endtask

	// An arena of zero size pins the point at the origin; a target there gives a
	// zero offset again, this time at position zero.
	task automatic test_zero_arena();
		set_all_regs(0, 0, 2047, 0);
		send_tick(1'b1, 12'hFFF, 12'hFFF);
		send_tick(1'b0, 12'hFFF, 12'hFFF);
		send_tick(1'b1, '0, '0);
		drain();
	endtask

	// Full arena, full gain and friction that barely damps: steering from the
	// origin toward the far corner builds speed until the velocity limit holds.
	task automatic test_velocity_limit();
		set_all_regs(4095, 4095, 2047, 65535);
		repeat (14) send_tick(1'b1, 12'hFFF, 12'hFFF);
		drain();
	endtask

	function automatic int pick_arena();
		case ($urandom_range(9))
			0: return 4095;
			1: return 1;
			2: return 0;
			default: return $urandom_range(4095, 1);
		endcase
	endfunction

	function automatic int pick_gain();
		case ($urandom_range(9))
			0: return 0;
			1: return 1024;
			2: return 2047;
			default: return $urandom_range(1024);
		endcase
	endfunction

	function automatic int pick_friction();
		case ($urandom_range(9))
			0: return 0;
			1: return 65535;
			2: return 62259;
			default: return $urandom_range(65535);
		endcase
	endfunction

	// Several register settings in turn, each followed by a run of random ticks.
	task automatic test_random_settings();
		for (int phase = 0; phase < 7; phase++) begin
			set_all_regs(pick_arena(), pick_arena(), pick_gain(), pick_friction());
			repeat (150) send_random_tick();
			drain();
		end
	endtask

	// A long stretch of back-to-back transfers with neither side idling.
	task automatic test_no_idle();
		set_all_regs(1200, 800, 128, 62259);
		idle_pct = 0;
		repeat (150) send_random_tick();
		drain();
		idle_pct = 11;
	endtask

	// The receiver holds off for a long time while ticks keep coming, so the
	// held result fills the output and the block stalls its input behind it.
	task automatic test_output_backpressure();
		set_all_regs(pick_arena(), pick_arena(), pick_gain(), pick_friction());
		hold_left = 400;
		repeat (100) send_random_tick();
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Tracked state matches what reset leaves in the block.
		arena_w_cfg = pmsb_pkg::ARENA_W_RST;
		arena_h_cfg = pmsb_pkg::ARENA_H_RST;
		gain_cfg = pmsb_pkg::GAIN_RST;
		fric_cfg = pmsb_pkg::FRIC_RST;
		trk_px = longint'(pmsb_pkg::POS_X_RST);
		trk_py = longint'(pmsb_pkg::POS_Y_RST);
		trk_vx = longint'(pmsb_pkg::VEL_RST);
		trk_vy = longint'(pmsb_pkg::VEL_RST);

		test_reset_state();
		test_shrunken_arena();
		test_zero_arena();
		test_velocity_limit();
		test_random_settings();
		test_no_idle();
		test_output_backpressure();

		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// A correct run ends well before this.
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
